// ----- design/cmst_pkg.sv -----
`default_nettype none

package cmst_pkg;

  // Item kinds
  localparam logic [1:0] FUNC_TICK  = 2'd0;
  localparam logic [1:0] FUNC_READ  = 2'd1;
  localparam logic [1:0] FUNC_WRITE = 2'd2;

  // Word register map
  localparam logic [2:0] IDX_STATUS = 3'd0;
  localparam logic [2:0] IDX_CNT_LO = 3'd1;
  localparam logic [2:0] IDX_CNT_HI = 3'd2;
  localparam logic [2:0] IDX_CMP0   = 3'd3;

  // Status word field offsets
  localparam int SHIFT_ENABLE      = 4;
  localparam int SHIFT_ENABLE_SYNC = 8;
  localparam int SHIFT_VALUE_SYNC  = 12;

  localparam int MAX_CHANNELS = 4;
  localparam int CNT_W        = 64;
  localparam int WORD_W       = 32;

  typedef struct packed {
    logic [WORD_W-1:0] write_data;
    logic [2:0]        reg_index;
    logic [1:0]        func;
  } item_t;

  typedef struct packed {
    logic [MAX_CHANNELS-1:0] irq_lines;
    logic [WORD_W-1:0]       read_data;
  } result_t;

endpackage

`default_nettype wire

// ----- design/compare_match_system_timer.sv -----
// System timer: 64-bit free-running counter with compare-match channels.
//
// Input channel (in_*): one item per handshake. in_tuser carries the item kind
// (tick, bus read, bus write) and the word register index; in_tdata carries
// the write data. Output channel (out_*): exactly one result item per input
// item, in order: the read data (zero unless a bus read) and the interrupt
// lines, which equal the sticky match flags after the item.
//
// Pipeline: an accepted item sits in the input register, is executed against
// the timer state once the output register is free or draining, and its result
// lands in the output register, from which it is offered on out_*.
// One item per cycle while out_tready stays high, set by the 64-bit increment
// and four parallel 32-bit compares between the two registers.
//
// Reset (rst_n low, synchronous): counter, compare values, enables and match
// flags go to zero; both pipeline registers empty.
// Stall: while out_tready is low the result holds; the input register holds
// its item and in_tready drops once it is full, so nothing is lost.
`default_nettype none

module compare_match_system_timer #(
  parameter int CHANNELS = 4
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // [31:0] write_data
  input  wire logic [4:0]  in_tuser,   // [1:0] func, [4:2] reg_index
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata   // [31:0] read_data, [35:32] irq_lines, [39:36] zero
);

  logic              s1_valid_r;
  cmst_pkg::item_t   s1_item_r;
  logic              out_valid_r;
  cmst_pkg::result_t out_res_r;
  cmst_pkg::result_t exec_res;
  logic              advance;
  logic              exec;

  // Move the held item forward when the output register is free or draining.
  assign advance   = !out_valid_r || out_tready;
  assign exec      = s1_valid_r && advance;
  assign in_tready = !s1_valid_r || advance;

  // Input register: load on accept, drop once executed.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_item_r.func       <= in_tuser[1:0];
      s1_item_r.reg_index  <= in_tuser[4:2];
      s1_item_r.write_data <= in_tdata;
    end
  end

  cmst_regs #(
    .CHANNELS (CHANNELS)
  ) u_regs (
    .clk      (clk),
    .rst_n    (rst_n),
    .exec_i   (exec),
    .item_i   (s1_item_r),
    .result_o (exec_res)
  );

  // Output register: hold while the receiver stalls.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      out_res_r <= exec_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0, out_res_r.irq_lines, out_res_r.read_data};

`ifndef NO_ASSERTIONS
  a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !advance |=> s1_valid_r && $stable(s1_item_r))
    else $error("pending item lost while output stalled");

  a_exec_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    exec |=> out_valid_r)
    else $error("executed item produced no result");

  a_stall_no_exec: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_tready |-> !exec)
    else $error("item executed while result was stalled");
`endif

endmodule

`default_nettype wire

// ----- design/cmst_regs.sv -----
`default_nettype none

module cmst_regs #(
  parameter int CHANNELS = 4
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            exec_i,
  input  wire cmst_pkg::item_t item_i,
  output cmst_pkg::result_t    result_o
);

  logic [cmst_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [cmst_pkg::WORD_W-1:0] cmp_r   [CHANNELS];
  logic [cmst_pkg::WORD_W-1:0] cmp_nxt [CHANNELS];
  logic [CHANNELS-1:0]         en_r, en_nxt;
  logic [CHANNELS-1:0]         flags_r, flags_nxt;
  logic [cmst_pkg::CNT_W-1:0]  cnt_inc;
  logic [cmst_pkg::WORD_W-1:0] status_word;
  logic [cmst_pkg::WORD_W-1:0] rd;
  logic [cmst_pkg::WORD_W-1:0] cmp_rd;
  logic                        is_tick, is_read, is_write;

  assign is_tick  = (item_i.func == cmst_pkg::FUNC_TICK);
  assign is_read  = (item_i.func == cmst_pkg::FUNC_READ);
  assign is_write = (item_i.func == cmst_pkg::FUNC_WRITE);
  assign cnt_inc  = cnt_r + cmst_pkg::CNT_W'(1);

  // status: match, enable, enable sync (mirrors enable), value sync (always one)
  always_comb begin
    status_word = '0;
    cmp_rd      = '0;
    for (int c = 0; c < CHANNELS; c++) begin
      status_word[c]                               = flags_r[c];
      status_word[cmst_pkg::SHIFT_ENABLE + c]      = en_r[c];
      status_word[cmst_pkg::SHIFT_ENABLE_SYNC + c] = en_r[c];
      status_word[cmst_pkg::SHIFT_VALUE_SYNC + c]  = 1'b1;
      if (item_i.reg_index == 3'(cmst_pkg::IDX_CMP0 + 3'(c))) begin
        cmp_rd = cmp_r[c];
      end
    end
  end

  always_comb begin
    rd = '0;
    if (is_read) begin
      unique case (item_i.reg_index)
        cmst_pkg::IDX_STATUS: rd = status_word;
        cmst_pkg::IDX_CNT_LO: rd = cnt_r[cmst_pkg::WORD_W-1:0];
        cmst_pkg::IDX_CNT_HI: rd = cnt_r[cmst_pkg::CNT_W-1:cmst_pkg::WORD_W];
        default:              rd = cmp_rd;
      endcase
    end
  end

  always_comb begin
    cnt_nxt   = cnt_r;
    en_nxt    = en_r;
    flags_nxt = flags_r;
    for (int c = 0; c < CHANNELS; c++) begin
      cmp_nxt[c] = cmp_r[c];
    end
    if (is_tick) begin
      cnt_nxt = cnt_inc;
      for (int c = 0; c < CHANNELS; c++) begin
        if (en_r[c] && (cmp_r[c] == cnt_inc[cmst_pkg::WORD_W-1:0])) begin
          flags_nxt[c] = 1'b1;
        end
      end
    end else if (is_write) begin
      if (item_i.reg_index == cmst_pkg::IDX_STATUS) begin
        flags_nxt = flags_r & ~item_i.write_data[CHANNELS-1:0];
        en_nxt    = item_i.write_data[cmst_pkg::SHIFT_ENABLE +: CHANNELS];
      end
      for (int c = 0; c < CHANNELS; c++) begin
        if (item_i.reg_index == 3'(cmst_pkg::IDX_CMP0 + 3'(c))) begin
          cmp_nxt[c] = item_i.write_data;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      en_r    <= '0;
      flags_r <= '0;
      for (int c = 0; c < CHANNELS; c++) begin
        cmp_r[c] <= '0;
      end
    end else if (exec_i) begin
      cnt_r   <= cnt_nxt;
      en_r    <= en_nxt;
      flags_r <= flags_nxt;
      for (int c = 0; c < CHANNELS; c++) begin
        cmp_r[c] <= cmp_nxt[c];
      end
    end
  end

  always_comb begin
    result_o           = '0;
    result_o.read_data = rd;
    result_o.irq_lines = cmst_pkg::MAX_CHANNELS'(flags_nxt);
  end

`ifndef NO_ASSERTIONS
  a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !exec_i |=> $stable(cnt_r) && $stable(en_r) && $stable(flags_r))
    else $error("timer state changed without an item");

  a_tick_inc: assert property (@(posedge clk) disable iff (!rst_n)
    exec_i && is_tick |=> cnt_r == cmst_pkg::CNT_W'($past(cnt_r) + 64'd1))
    else $error("counter did not advance by one on a tick");

  a_no_set_off_tick: assert property (@(posedge clk) disable iff (!rst_n)
    exec_i && !is_tick |=> (flags_r & ~$past(flags_r)) == '0)
    else $error("match flag set by an item other than a tick");

  a_read_no_side: assert property (@(posedge clk) disable iff (!rst_n)
    exec_i && is_read |=> $stable(cnt_r) && $stable(en_r) && $stable(flags_r))
    else $error("bus read changed timer state");
`endif

endmodule

`default_nettype wire

// ----- tb/compare_match_system_timer_tb.sv -----
`timescale 1ns / 1ps

module compare_match_system_timer_tb;

  // Codes the package leaves unnamed: the spare item kind and the spare index
  localparam logic [1:0] FUNC_NONE  = 2'd3;
  localparam logic [2:0] IDX_UNUSED = 3'd7;

  localparam int DIR_ROWS       = 25;
  localparam int RAND_ITEMS     = 750;
  localparam int RX_HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES   = 8;

  // One row of the directed table; res is only used where typed is set
  typedef struct packed {
    logic [1:0]        func;
    logic [2:0]        idx;
    logic [31:0]       data;
    bit                typed;
    cmst_pkg::result_t res;
  } stim_row_t;

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata   = '0;   // [31:0] write_data
  logic [4:0]  in_tuser   = '0;   // [1:0] func, [4:2] reg_index
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;         // [31:0] read_data, [35:32] irq_lines, [39:36] zero

  // Typed expectation that travels with the item on the bus
  bit                tag_typed = 1'b0;
  cmst_pkg::result_t tag_res   = '0;

  // Shadow copy of the timer state
  logic [63:0] tmr_count;
  logic [31:0] tmr_cmp [cmst_pkg::MAX_CHANNELS];
  logic [3:0]  tmr_en;
  logic [3:0]  tmr_match;

  cmst_pkg::result_t timer_result_q [$];
  cmst_pkg::result_t pred_res;
  cmst_pkg::result_t chk_exp;

  stim_row_t   dir_tbl [DIR_ROWS];

  int          sent_count  = 0;
  int          rcv_count   = 0;
  int          ticks_sent  = 0;
  int          fail_count  = 0;
  int          rx_items    = 0;
  bit          tx_burst    = 1'b0;
  bit          rx_burst    = 1'b0;
  bit          rx_hold_req = 1'b0;

  compare_match_system_timer #(
    .CHANNELS(4)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Apply one item to the shadow timer state and return the result it yields
  function automatic cmst_pkg::result_t timer_step(logic [1:0] f, logic [2:0] idx,
                                                   logic [31:0] d);
    cmst_pkg::result_t r;
    r.read_data = '0;
    case (f)
      cmst_pkg::FUNC_TICK: begin
        tmr_count = tmr_count + 64'd1;
        // compare against the new low word, only enabled channels latch
        for (int c = 0; c < cmst_pkg::MAX_CHANNELS; c++) begin
          if (tmr_en[c] && tmr_cmp[c] == tmr_count[31:0])
            tmr_match[c] = 1'b1;
        end
      end
      cmst_pkg::FUNC_READ: begin
        case (idx)
          cmst_pkg::IDX_STATUS: r.read_data = {16'h0, 4'hF, tmr_en, tmr_en, tmr_match};
          cmst_pkg::IDX_CNT_LO: r.read_data = tmr_count[31:0];
          cmst_pkg::IDX_CNT_HI: r.read_data = tmr_count[63:32];
          IDX_UNUSED:           r.read_data = '0;
          default:              r.read_data = tmr_cmp[2'(idx - cmst_pkg::IDX_CMP0)];
        endcase
      end
      cmst_pkg::FUNC_WRITE: begin
        // counter halves and the spare index ignore writes
        if (idx == cmst_pkg::IDX_STATUS) begin
          tmr_match = tmr_match & ~d[3:0];
          tmr_en    = d[cmst_pkg::SHIFT_ENABLE +: 4];
        end else if (idx >= cmst_pkg::IDX_CMP0 && idx != IDX_UNUSED) begin
          tmr_cmp[2'(idx - cmst_pkg::IDX_CMP0)] = d;
        end
      end
      default: ;
    endcase
    r.irq_lines = tmr_match;
    return r;
  endfunction

  // Drive one item after a random gap and hold it until the block takes it
  task automatic send_item(input logic [1:0] f, input logic [2:0] idx, input logic [31:0] d,
                           input bit typed, input cmst_pkg::result_t typed_res);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= {idx, f};
    in_tdata  <= d;
    tag_typed <= typed;
    tag_res   <= typed_res;
    do @(posedge clk); while (!in_tready);
    sent_count++;
    if (f == cmst_pkg::FUNC_TICK) ticks_sent++;
  endtask

  // Predict on every accepted item; typed rows replace the prediction
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      pred_res = timer_step(in_tuser[1:0], in_tuser[4:2], in_tdata);
      if (tag_typed) pred_res = tag_res;
      timer_result_q.push_back(pred_res);
    end
  end

  // Compare every accepted result with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      rcv_count++;
      if (timer_result_q.size() == 0) begin
        $error("result with nothing expected: out_tdata=%h", out_tdata);
        fail_count++;
      end else begin
        chk_exp = timer_result_q.pop_front();
        if (out_tdata[31:0] !== chk_exp.read_data) begin
          $error("read_data: expected %h, actual %h", chk_exp.read_data, out_tdata[31:0]);
          fail_count++;
        end
        if (out_tdata[35:32] !== chk_exp.irq_lines) begin
          $error("irq_lines: expected %h, actual %h", chk_exp.irq_lines, out_tdata[35:32]);
          fail_count++;
        end
        if (out_tdata[39:36] !== 4'h0) begin
          $error("pad: expected 0, actual %h", out_tdata[39:36]);
          fail_count++;
        end
      end
    end
  end

  // Receiver: random stalls per item, bursts without stalls, one long hold on request
  initial begin : rx_proc
    int gap;
    wait (rst_n);
    forever begin
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
      end
      gap = rx_burst ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      rx_items++;
      if (rx_items % 40 == 0) rx_burst = ($urandom_range(0, 2) == 0);
    end
  end

  // Main sequence: reset, directed table, random items, drain, verdict
  initial begin : stim_proc
    int          pick;
    logic [1:0]  f;
    logic [2:0]  idx;
    logic [31:0] d;

    tmr_count = '0;
    tmr_en    = '0;
    tmr_match = '0;
    for (int c = 0; c < cmst_pkg::MAX_CHANNELS; c++) tmr_cmp[c] = '0;

    dir_tbl = '{
      // right after reset: value sync bits read one, everything else zero
      '{cmst_pkg::FUNC_READ,  cmst_pkg::IDX_STATUS,      32'h0, 1'b1, {4'h0, 32'h0000_F000}},
      '{cmst_pkg::FUNC_READ,  cmst_pkg::IDX_CNT_LO,      32'h0, 1'b1, {4'h0, 32'h0}},
      '{cmst_pkg::FUNC_READ,  cmst_pkg::IDX_CNT_HI,      32'h0, 1'b1, {4'h0, 32'h0}},
      '{cmst_pkg::FUNC_READ,  IDX_UNUSED,                32'h0, 1'b1, {4'h0, 32'h0}},
      '{cmst_pkg::FUNC_READ,  cmst_pkg::IDX_CMP0,        32'h0, 1'b1, {4'h0, 32'h0}},
      '{cmst_pkg::FUNC_READ,  cmst_pkg::IDX_CMP0 + 3'd3, 32'h0, 1'b1, {4'h0, 32'h0}},
      // spare item kind leaves the state alone
      '{FUNC_NONE,            cmst_pkg::IDX_STATUS, 32'hFFFF_FFFF, 1'b1, {4'h0, 32'h0}},
      '{cmst_pkg::FUNC_READ,  cmst_pkg::IDX_STATUS,      32'h0, 1'b1, {4'h0, 32'h0000_F000}},
      // counter halves and the spare index drop writes
      '{cmst_pkg::FUNC_WRITE, cmst_pkg::IDX_CNT_LO, 32'hFFFF_FFFF, 1'b1, {4'h0, 32'h0}},
      '{cmst_pkg::FUNC_WRITE, cmst_pkg::IDX_CNT_HI, 32'hFFFF_FFFF, 1'b1, {4'h0, 32'h0}},
      '{cmst_pkg::FUNC_WRITE, IDX_UNUSED,           32'hFFFF_FFFF, 1'b1, {4'h0, 32'h0}},
      '{cmst_pkg::FUNC_READ,  cmst_pkg::IDX_CNT_HI,      32'h0, 1'b1, {4'h0, 32'h0}},
      // load compares, enable all, then tick into two matches
      '{cmst_pkg::FUNC_WRITE, cmst_pkg::IDX_CMP0,        32'h0000_0002, 1'b0, '0},
      '{cmst_pkg::FUNC_WRITE, cmst_pkg::IDX_CMP0 + 3'd1, 32'hFFFF_FFFF, 1'b0, '0},
      '{cmst_pkg::FUNC_WRITE, cmst_pkg::IDX_CMP0 + 3'd3, 32'h0000_0001, 1'b0, '0},
      '{cmst_pkg::FUNC_WRITE, cmst_pkg::IDX_STATUS,      32'h0000_00F0, 1'b0, '0},
      '{cmst_pkg::FUNC_TICK,  cmst_pkg::IDX_STATUS,      32'hFFFF_FFFF, 1'b0, '0},
      '{cmst_pkg::FUNC_TICK,  IDX_UNUSED,                32'h0000_0000, 1'b0, '0},
      '{cmst_pkg::FUNC_READ,  cmst_pkg::IDX_STATUS,      32'h0000_0000, 1'b0, '0},
      // write-one-to-clear channel 0, keep enables
      '{cmst_pkg::FUNC_WRITE, cmst_pkg::IDX_STATUS,      32'h0000_00F1, 1'b0, '0},
      // compare loaded equal to the current low word must not match by itself
      '{cmst_pkg::FUNC_WRITE, cmst_pkg::IDX_CMP0 + 3'd2, 32'h0000_0002, 1'b0, '0},
      '{cmst_pkg::FUNC_READ,  cmst_pkg::IDX_CMP0 + 3'd1, 32'h0000_0000, 1'b0, '0},
      '{cmst_pkg::FUNC_WRITE, cmst_pkg::IDX_STATUS,      32'hFFFF_FFFF, 1'b0, '0},
      '{cmst_pkg::FUNC_TICK,  cmst_pkg::IDX_CMP0,        32'h0000_0000, 1'b0, '0},
      '{cmst_pkg::FUNC_READ,  cmst_pkg::IDX_CNT_LO,      32'h0000_0000, 1'b0, '0}
    };

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < DIR_ROWS; i++)
      send_item(dir_tbl[i].func, dir_tbl[i].idx, dir_tbl[i].data,
                dir_tbl[i].typed, dir_tbl[i].res);

    for (int i = 0; i < RAND_ITEMS; i++) begin
      if (i % 50 == 0) tx_burst = ($urandom_range(0, 3) == 0);
      // stall the receiver for a long stretch while items keep coming
      if (i == 250) begin
        rx_hold_req = 1'b1;
        tx_burst    = 1'b1;
      end
      // drop valid and pause until every result is back
      if (i == 500) begin
        in_tvalid <= 1'b0;
        wait (rcv_count == sent_count);
      end

      pick = $urandom_range(0, 99);
      idx  = 3'($urandom_range(0, 7));
      d    = $urandom;
      if (pick < 45) begin
        f = cmst_pkg::FUNC_TICK;
      end else if (pick < 68) begin
        f = cmst_pkg::FUNC_READ;
      end else if (pick < 95) begin
        f = cmst_pkg::FUNC_WRITE;
        if (pick < 80) begin
          // aim most compares just ahead of the counter so matches fire
          idx = cmst_pkg::IDX_CMP0 + 3'($urandom_range(0, 3));
          if ($urandom_range(0, 3) != 0) d = 32'(ticks_sent) + 32'($urandom_range(0, 12));
        end else if (pick < 90) begin
          idx = cmst_pkg::IDX_STATUS;
        end
      end else begin
        f = FUNC_NONE;
      end
      send_item(f, idx, d, 1'b0, '0);
    end

    in_tvalid <= 1'b0;
    wait (rcv_count == sent_count);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (timer_result_q.size() != 0) begin
      $error("%0d expected results never arrived", timer_result_q.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Hard stop well past the slowest legal run
  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
